// File: rtl/core/base85_decoder_stream_macros.svh
// ----------------------------------------------------------------------------
// Base85 decoder stream assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BASE85_DECODER_STREAM_MACROS_SVH
`define BASE85_DECODER_STREAM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B85D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B85D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/b85d_pkg.sv
// ----------------------------------------------------------------------------
// Base85 decoder package
// Status codes, the job record passed from front to back, and the symbol
// and digit-weight tables.
// ----------------------------------------------------------------------------
package b85d_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_TAIL   = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_NO_HEADER  = 3'd4
  } status_t;

  // One request for the back end: up to four bytes of word, most
  // significant first, then optionally the end-of-message status.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        has_status;
    status_t     status;
  } job_t;

  localparam logic [6:0] NO_SYMBOL  = 7'h7F;
  localparam logic [6:0] MAX_TAIL   = 7'd4;
  localparam logic [2:0] LAST_DIGIT = 3'd4;
  localparam logic [2:0] MIN_CHARS  = 3'd6;
  localparam logic [2:0] SHORT_OK   = 3'd2;
  localparam logic [2:0] FULL_GROUP = 3'd4;

  function automatic logic [6:0] symbol_value(input logic [7:0] c);
    logic [6:0] v;
    v = NO_SYMBOL;
    if (c inside {[8'h41:8'h5A]}) begin
      v = 7'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else begin
      case (c)
        8'h21:   v = 7'd62;
        8'h24:   v = 7'd63;
        8'h25:   v = 7'd64;
        8'h26:   v = 7'd65;
        8'h28:   v = 7'd66;
        8'h29:   v = 7'd67;
        8'h2A:   v = 7'd68;
        8'h2D:   v = 7'd69;
        8'h2E:   v = 7'd70;
        8'h2F:   v = 7'd71;
        8'h3A:   v = 7'd72;
        8'h3B:   v = 7'd73;
        8'h3C:   v = 7'd74;
        8'h3D:   v = 7'd75;
        8'h3E:   v = 7'd76;
        8'h3F:   v = 7'd77;
        8'h40:   v = 7'd78;
        8'h5B:   v = 7'd79;
        8'h5D:   v = 7'd80;
        8'h5E:   v = 7'd81;
        8'h2C:   v = 7'd82;
        8'h5F:   v = 7'd83;
        8'h7C:   v = 7'd84;
        default: v = NO_SYMBOL;
      endcase
    end
    return v;
  endfunction

  // Big-endian weight of a digit position within a five-digit group.
  function automatic logic [25:0] digit_weight(input logic [2:0] pos);
    logic [25:0] w;
    case (pos)
      3'd0:    w = 26'd52200625;
      3'd1:    w = 26'd614125;
      3'd2:    w = 26'd7225;
      3'd3:    w = 26'd85;
      default: w = 26'd1;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/b85d_front.sv
// ----------------------------------------------------------------------------
// Base85 decoder front end
// Classifies each accepted character, updates the group and header state,
// and posts a job for every character that causes output.
// ----------------------------------------------------------------------------
module b85d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       in_char,
  input  logic             msg_last,
  output logic             push,
  output b85d_pkg::job_t   job
);
  import b85d_pkg::*;

  logic [31:0] accumulator, accumulator_next;
  logic [2:0]  digit_count, digit_count_next;
  logic        header_seen, header_seen_next;
  logic [2:0]  tail_length, tail_length_next;
  logic [31:0] held_group, held_group_next;
  logic        held_valid, held_valid_next;
  logic [2:0]  char_count, char_count_next;
  logic        bad_tail, bad_tail_next;

  logic [6:0]  sym;
  logic [31:0] product;
  logic [31:0] sum;
  logic        release_held;
  status_t     st;

  assign sym     = symbol_value(in_char);
  assign product = 32'(sym) * 32'(digit_weight(digit_count));
  assign sum     = accumulator + product;

  always_comb begin
    accumulator_next = accumulator;
    digit_count_next = digit_count;
    header_seen_next = header_seen;
    tail_length_next = tail_length;
    held_group_next  = held_group;
    held_valid_next  = held_valid;
    bad_tail_next    = bad_tail;
    release_held     = 1'b0;
    char_count_next  = (char_count < MIN_CHARS) ? char_count + 3'd1 : char_count;

    if (sym != NO_SYMBOL && !bad_tail) begin
      if (!header_seen) begin
        header_seen_next = 1'b1;
        if (sym > MAX_TAIL) begin
          bad_tail_next = 1'b1;
        end else begin
          tail_length_next = sym[2:0];
        end
      end else begin
        // A new group starting proves the held one is not the last.
        if (digit_count == 3'd0 && held_valid) begin
          release_held    = 1'b1;
          held_valid_next = 1'b0;
        end
        if (digit_count == LAST_DIGIT) begin
          held_group_next  = sum;
          held_valid_next  = 1'b1;
          accumulator_next = '0;
          digit_count_next = '0;
        end else begin
          accumulator_next = sum;
          digit_count_next = digit_count + 3'd1;
        end
      end
    end

    if (char_count_next < MIN_CHARS && char_count_next != SHORT_OK) begin
      st = ST_TOO_SHORT;
    end else if (bad_tail_next) begin
      st = ST_BAD_TAIL;
    end else if (!header_seen_next) begin
      st = ST_NO_HEADER;
    end else if (digit_count_next != 3'd0) begin
      st = ST_INCOMPLETE;
    end else if (!held_valid_next && tail_length_next != 3'd0
                 && tail_length_next != FULL_GROUP) begin
      st = ST_BAD_TAIL;
    end else begin
      st = ST_OK;
    end

    job.status     = st;
    job.has_status = msg_last;
    job.word       = release_held ? held_group : held_group_next;
    if (release_held) begin
      job.nbytes = FULL_GROUP;
    end else if (msg_last && held_valid_next) begin
      job.nbytes = (tail_length_next == 3'd0) ? FULL_GROUP : tail_length_next;
    end else begin
      job.nbytes = 3'd0;
    end
    push = take && (job.nbytes != 3'd0 || msg_last);
  end

  always_ff @(posedge clk) begin
    if (rst || (take && msg_last)) begin
      accumulator <= '0;
      digit_count <= '0;
      header_seen <= 1'b0;
      tail_length <= '0;
      held_group  <= '0;
      held_valid  <= 1'b0;
      char_count  <= '0;
      bad_tail    <= 1'b0;
    end else if (take) begin
      accumulator <= accumulator_next;
      digit_count <= digit_count_next;
      header_seen <= header_seen_next;
      tail_length <= tail_length_next;
      held_group  <= held_group_next;
      held_valid  <= held_valid_next;
      char_count  <= char_count_next;
      bad_tail    <= bad_tail_next;
    end
  end

endmodule

// File: rtl/core/b85d_queue.sv
// ----------------------------------------------------------------------------
// Base85 decoder job queue
// Small first-in first-out buffer of jobs between front and back end.
// DEPTH must be at least two.
// ----------------------------------------------------------------------------
`include "base85_decoder_stream_macros.svh"

module b85d_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b85d_pkg::job_t push_data,
  input  logic           pop,
  output b85d_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import b85d_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `B85D_ASSERT_SAME(a_no_pop_empty, pop, !empty, "job popped from an empty queue")
  `B85D_ASSERT_SAME(a_no_push_full, push, !full, "job pushed into a full queue")
  `B85D_ASSERT_SAME(a_count_range, 1'b1, count <= CNT_W'(DEPTH), "queue count overflow")
  `B85D_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count lost a push")

endmodule

// File: rtl/core/b85d_back.sv
// ----------------------------------------------------------------------------
// Base85 decoder back end
// Unpacks the job at the queue head into byte and status results, one per
// cycle while result_stall allows, through the output register.
// ----------------------------------------------------------------------------
module b85d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  b85d_pkg::job_t    q_head,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        out_byte,
  output logic              is_status,
  output b85d_pkg::status_t status,
  output logic              run_last
);
  import b85d_pkg::*;

  logic [2:0] idx;
  logic       advance;
  logic       cur_status;
  logic       cur_last;
  logic [7:0] cur_byte;

  assign advance    = !q_empty && (!result_valid || !result_stall);
  assign cur_status = (idx == q_head.nbytes);
  assign cur_last   = cur_status || (idx + 3'd1 == q_head.nbytes && !q_head.has_status);
  assign q_pop      = advance && cur_last;

  always_comb begin
    case (idx[1:0])
      2'd0:    cur_byte = q_head.word[31:24];
      2'd1:    cur_byte = q_head.word[23:16];
      2'd2:    cur_byte = q_head.word[15:8];
      default: cur_byte = q_head.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      idx          <= cur_last ? 3'd0 : idx + 3'd1;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= cur_status ? 8'd0 : cur_byte;
      is_status <= cur_status;
      status    <= cur_status ? q_head.status : ST_OK;
      run_last  <= cur_last;
    end
  end

endmodule

// File: rtl/core/base85_decoder_stream.sv
// ----------------------------------------------------------------------------
// Base85 decoder stream
// Decodes a base85 character stream with a custom alphabet into bytes and
// an end-of-message status.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid, item_stall) takes one character per cycle
// unless stalled, on in_char, with msg_last high on the final character of
// a message. The result channel (result_valid, result_stall) gives one
// result per cycle unless stalled: a data byte on out_byte, or with
// is_status high the message status. run_last marks the last result caused
// by a character. With the queue empty, an accepted character's job is
// written into the queue and its first result is then registered into the
// output register. A character gives zero to five results; the output
// register sends one per cycle unless stalled, so unstalled items giving at
// most one result flow at one per cycle, and a queue of QUEUE_DEPTH jobs
// absorbs the four or five result bursts. item_stall rises only when that
// queue is full. When the receiver stalls, the result register holds its
// value and the queue fills, after which item_stall is raised.
// Reset clears the decoder state and empties the queue; no clearing pass.
// Bytes delivered before an error status belong to a bad message.
// ----------------------------------------------------------------------------
module base85_decoder_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] in_char,
  input  logic       msg_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       is_status,
  output logic [2:0] status,
  output logic       run_last
);
  import b85d_pkg::*;

  logic    take;
  logic    push;
  job_t    push_job;
  job_t    head_job;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  status_t res_status;

  assign item_stall = q_full;
  assign take       = item_valid && !q_full;
  assign status     = res_status;

  b85d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_char  (in_char),
    .msg_last (msg_last),
    .push     (push),
    .job      (push_job)
  );

  b85d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (q_pop),
    .head      (head_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  b85d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (head_job),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .is_status    (is_status),
    .status       (res_status),
    .run_last     (run_last)
  );

endmodule

// File: verif/base85_decoder_stream_tb.sv
// ----------------------------------------------------------------------------
// Base85 decoder stream testbench
// Drives character requests with random gaps and result stalls, predicts
// each byte and status from a behavioral decoder copy or a typed row's code,
// and compares each delivered result in order. Short directed messages come
// first, then random ones, mostly well formed, with noise and broken ones.
// ----------------------------------------------------------------------------
module base85_decoder_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b85d_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 120;
  localparam int RANDOM_ITEMS   = 124;
  localparam int DRAIN_CYCLES   = 16;
  localparam int N_DIRECTED     = 26;
  localparam int N_SYMBOLS      = 85;

  typedef struct {
    logic [7:0] data;
    logic       flag;
    status_t    code;
    logic       last_of_run;
  } decoded_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    status_t    code;
  } char_row_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic [7:0] in_char      = 8'h00;
  logic       msg_last     = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte;
  logic       is_status;
  logic [2:0] status;
  logic       run_last;

  base85_decoder_stream u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .in_char      (in_char),
    .msg_last     (msg_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .is_status    (is_status),
    .status       (status),
    .run_last     (run_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  string symbol_order =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!$%&()*-./:;<=>?@[]^,_|";
  logic [31:0] place_weight [5] = '{32'd52200625, 32'd614125, 32'd7225, 32'd85, 32'd1};

  // Rows with a typed code give exactly one status result; the rest are
  // checked against the decoder copy below.
  char_row_t directed_rows [N_DIRECTED] = '{
    '{"A",   1'b1, 1'b1, ST_TOO_SHORT},
    '{"A",   1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b1, 1'b1, ST_NO_HEADER},
    '{"F",   1'b0, 1'b0, ST_OK},
    '{"~",   1'b1, 1'b1, ST_BAD_TAIL},
    '{"B",   1'b0, 1'b0, ST_OK},
    '{"#",   1'b1, 1'b1, ST_BAD_TAIL},
    '{"E",   1'b0, 1'b0, ST_OK},
    '{"|",   1'b0, 1'b0, ST_OK},
    '{"|",   1'b0, 1'b0, ST_OK},
    '{"|",   1'b0, 1'b0, ST_OK},
    '{"|",   1'b0, 1'b0, ST_OK},
    '{"|",   1'b0, 1'b0, ST_OK},
    '{"A",   1'b0, 1'b0, ST_OK},
    '{"A",   1'b0, 1'b0, ST_OK},
    '{"A",   1'b0, 1'b0, ST_OK},
    '{"A",   1'b0, 1'b0, ST_OK},
    '{"A",   1'b1, 1'b0, ST_OK},
    '{"C",   1'b0, 1'b0, ST_OK},
    '{"0",   1'b0, 1'b0, ST_OK},
    '{"9",   1'b0, 1'b0, ST_OK},
    '{"a",   1'b0, 1'b0, ST_OK},
    '{"z",   1'b0, 1'b0, ST_OK},
    '{"^",   1'b1, 1'b0, ST_OK}
  };

  decoded_t  pending_results [$];
  decoded_t  step_results [$];
  char_row_t message_chars [$];

  // Behavioral copy of the decoder state.
  logic [31:0] acc_word;
  logic [31:0] held_word;
  logic [2:0]  digit_pos;
  logic [2:0]  tail_bytes;
  logic [2:0]  chars_seen;
  logic        header_done;
  logic        held_full;
  status_t     sticky_code;

  int mismatch_count = 0;
  int idle_cycles    = 0;
  bit hold_request   = 1'b0;
  bit holding        = 1'b0;

  function automatic int alpha_index(input logic [7:0] ch);
    for (int k = 0; k < N_SYMBOLS; k++) begin
      if (8'(symbol_order[k]) == ch) return k;
    end
    return -1;
  endfunction

  function automatic logic [7:0] random_digit();
    case ($urandom_range(0, 9))
      0:       return "A";
      1:       return "|";
      default: return 8'(symbol_order[$urandom_range(0, N_SYMBOLS - 1)]);
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (alpha_index(c) >= 0);
    return c;
  endfunction

  task automatic clear_decoder();
    acc_word    = '0;
    held_word   = '0;
    digit_pos   = '0;
    tail_bytes  = '0;
    chars_seen  = '0;
    header_done = 1'b0;
    held_full   = 1'b0;
    sticky_code = ST_OK;
  endtask

  task automatic emit_word(input logic [31:0] word, input logic [2:0] count);
    for (int i = 0; i < count; i++) begin
      step_results.push_back('{8'(word >> (24 - 8 * i)), 1'b0, ST_OK, 1'b0});
    end
  endtask

  task automatic decode_step(input logic [7:0] ch, input logic last);
    int      v;
    status_t code;
    step_results.delete();
    if (chars_seen < 3'd6) chars_seen++;
    v = alpha_index(ch);
    if (v >= 0 && sticky_code == ST_OK) begin
      if (!header_done) begin
        header_done = 1'b1;
        if (v > 4) sticky_code = ST_BAD_TAIL;
        else tail_bytes = 3'(v);
      end else begin
        // A new group starting proves the held one was not the last.
        if (digit_pos == 3'd0 && held_full) begin
          emit_word(held_word, 3'd4);
          held_full = 1'b0;
        end
        acc_word = acc_word + 32'(v) * place_weight[digit_pos];
        digit_pos++;
        if (digit_pos == 3'd5) begin
          held_word = acc_word;
          held_full = 1'b1;
          acc_word  = '0;
          digit_pos = '0;
        end
      end
    end
    if (last) begin
      if (held_full) emit_word(held_word, (tail_bytes == 3'd0) ? 3'd4 : tail_bytes);
      if (chars_seen < 3'd6 && chars_seen != 3'd2) code = ST_TOO_SHORT;
      else if (sticky_code != ST_OK) code = ST_BAD_TAIL;
      else if (!header_done) code = ST_NO_HEADER;
      else if (digit_pos != 3'd0) code = ST_INCOMPLETE;
      else if (!held_full && tail_bytes >= 3'd1 && tail_bytes <= 3'd3) code = ST_BAD_TAIL;
      else code = ST_OK;
      step_results.push_back('{8'h00, 1'b1, code, 1'b0});
      clear_decoder();
    end
    if (step_results.size() > 0) step_results[$].last_of_run = 1'b1;
  endtask

  // Offers one character request, waits for it to be taken, then records
  // what it should produce.
  task automatic offer_char(input logic [7:0] ch, input logic last, input int gap,
                            input logic typed, input status_t code);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    in_char    <= ch;
    msg_last   <= last;
    do @(posedge clk); while (item_stall);
    decode_step(ch, last);
    if (typed) begin
      pending_results.push_back('{8'h00, 1'b1, code, 1'b1});
    end else begin
      while (step_results.size() > 0) pending_results.push_back(step_results.pop_front());
    end
  endtask

  task automatic add_char(input logic [7:0] ch);
    message_chars.push_back('{ch, 1'b0, 1'b0, ST_OK});
  endtask

  task automatic fill_message();
    int groups;
    int extra;
    int len;
    message_chars.delete();
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 9) == 0) add_char(noise_char());
      if ($urandom_range(0, 9) == 0) begin
        add_char(8'(symbol_order[$urandom_range(5, N_SYMBOLS - 1)]));
      end else begin
        add_char(8'(symbol_order[$urandom_range(0, 4)]));
      end
      groups = $urandom_range(0, 3);
      extra  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      for (int g = 0; g < groups * 5 + extra; g++) begin
        if ($urandom_range(0, 9) == 0) add_char(noise_char());
        add_char(random_digit());
      end
      if ($urandom_range(0, 3) == 0) add_char(noise_char());
    end else begin
      len = $urandom_range(1, 10);
      repeat (len) begin
        if ($urandom_range(0, 1) == 1) add_char(random_digit());
        else add_char(8'($urandom_range(0, 255)));
      end
    end
    message_chars[$].last = 1'b1;
  endtask

  initial begin
    int sent;
    bit burst;
    int gap;
    clear_decoder();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      offer_char(directed_rows[r].ch, directed_rows[r].last, $urandom_range(0, 10),
                 directed_rows[r].typed, directed_rows[r].code);
    end
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // The receiver holds off for a while as the random part opens, so the
    // input side is pushed into stalling.
    hold_request = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      fill_message();
      burst = ($urandom_range(0, 3) == 0);
      foreach (message_chars[i]) begin
        gap = (burst || holding) ? 0 : $urandom_range(0, 10);
        offer_char(message_chars[i].ch, message_chars[i].last, gap, 1'b0, ST_OK);
        sent++;
      end
    end
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int n;
    int quick;
    quick = 0;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holding      = 1'b1;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
      end
      if (quick > 0) begin
        quick--;
        n = 0;
      end else begin
        n = $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) quick = $urandom_range(5, 30);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: byte=%02h is_status=%0b status=%0d run_last=%0b",
                   out_byte, is_status, status, run_last);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.data || is_status !== want.flag ||
            status !== want.code || run_last !== want.last_of_run) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"mismatch: expected byte=%02h is_status=%0b status=%0d run_last=%0b,",
                      " got byte=%02h is_status=%0b status=%0d run_last=%0b"},
                     want.data, want.flag, want.code, want.last_of_run,
                     out_byte, is_status, status, run_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/b85d_pkg.sv
rtl/core/b85d_front.sv
rtl/core/b85d_queue.sv
rtl/core/b85d_back.sv
rtl/core/base85_decoder_stream.sv
verif/base85_decoder_stream_tb.sv
